// File: sv/dpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_pkg: shared types and constants of the divisor pair enumerator
// widths, mode codes, microcode word layout and control/flag bundles
// ----------------------------------------------------------------------------
package dpe_pkg;

    localparam int FIELD_W     = 16;                 // payload field width at the ports
    localparam int KIND_W      = 2;
    localparam int VALUE_WIDTH = 16;                 // bits of value/bound actually used
    localparam int SQ_W        = 2 * VALUE_WIDTH;
    localparam int RADIX_BITS  = 4;                  // quotient bits per divider cycle
    localparam int DIV_STEPS   = (VALUE_WIDTH + RADIX_BITS - 1) / RADIX_BITS;
    localparam int DIV_W       = DIV_STEPS * RADIX_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int STEP_W      = 4;                  // microprogram counter width

    typedef enum logic [KIND_W-1:0] {
        MODE_ALL    = 2'd0,
        MODE_MAX    = 2'd1,
        MODE_MIN    = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQUARE,
        OP_DIV_GO,
        OP_EMIT,
        OP_INC,
        OP_FINISH
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_REQ,
        C_TEST_FAIL,
        C_DIV_BUSY,
        C_NO_HIT,
        C_OUT_BUSY
    } t_cond;

    // one microcode word: operation, jump condition, jump target
    // gate = 1 suppresses the operation when the jump is taken
    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic              gate;
        logic [STEP_W-1:0] target;
    } t_ucw;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctl;

    typedef struct packed {
        logic req_valid;
        logic test_fail;
        logic div_busy;
        logic no_hit;
        logic out_busy;
    } t_flags;

endpackage

// File: sv/dpe_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_req_if: request channel of the divisor pair enumerator
// valid/ready handshake carrying kind, value and bound
// ----------------------------------------------------------------------------
interface dpe_req_if import dpe_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] bound;

    modport source (output valid, kind, value, bound, input ready);
    modport sink   (input valid, kind, value, bound, output ready);
endinterface

// File: sv/dpe_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_rsp_if: result channel of the divisor pair enumerator
// valid/ready handshake carrying one divisor pair and its flags
// ----------------------------------------------------------------------------
interface dpe_rsp_if import dpe_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] first_factor;
    logic [FIELD_W-1:0] second_factor;
    logic               pair_valid;
    logic               last;

    modport source (output valid, first_factor, second_factor, pair_valid, last,
                    input ready);
    modport sink   (input valid, first_factor, second_factor, pair_valid, last,
                    output ready);
endinterface

// File: sv/divisor_pair_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_pair_enumerator: trial-division divisor pair enumerator
// takes kind/value/bound on the request channel and returns the divisor pairs
// i * (value / i) that the kind keeps, i up to the root, one result per pair
// ----------------------------------------------------------------------------
// usage
//   - request channel i_req: one request (kind, value, bound) is taken when
//     valid and ready are both high; ready is high only while the block idles
//   - result channel o_rsp: one result per kept pair in ascending order of
//     the smaller divisor; the final result of a request has last set; a
//     request with no kept pair gives a single result with pair_valid low
//   - the serial microprogram runs around one divider that yields 4 quotient
//     bits per cycle; it tries one candidate at a time, from the start value
//     up to the integer square root (at most 255 for a 16-bit value)
//   - a result is kept back one pair so its last flag is known; it goes to
//     a single output register, so the next request is taken while the
//     closing result still waits there
//   - receiver stall: the sequencer holds at the emit or finish step until
//     the output register frees up; no result is dropped or repeated
//   - reset (synchronous, active low) returns the sequencer to idle and
//     clears the valid flags of the pending pair and the output register
// ----------------------------------------------------------------------------
module divisor_pair_enumerator import dpe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dpe_req_if.sink  i_req,
    dpe_rsp_if.source o_rsp
);

    // control word from the sequencer and status flags back from the datapath
    t_ctl   w_ctl;
    t_flags w_flags;

    // microprogram: idle/load, square, test, divide, check, emit, step, finish, back
    dpe_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    // datapath with divider, pending pair and result register
    dpe_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_flags         (w_flags),
        .i_req_valid     (i_req.valid),
        .i_kind          (i_req.kind),
        .i_value         (i_req.value),
        .i_bound         (i_req.bound),
        .o_req_ready     (i_req.ready),
        .o_rsp_valid     (o_rsp.valid),
        .i_rsp_ready     (o_rsp.ready),
        .o_first_factor  (o_rsp.first_factor),
        .o_second_factor (o_rsp.second_factor),
        .o_pair_valid    (o_rsp.pair_valid),
        .o_last          (o_rsp.last)
    );

endmodule

// File: sv/dpe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_div: iterative unsigned divider
// restoring division, RADIX_BITS quotient bits per cycle, registered result
// ----------------------------------------------------------------------------
module dpe_div import dpe_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_busy,
    output logic [VALUE_WIDTH-1:0] o_quot,
    output logic [VALUE_WIDTH-1:0] o_rem
);

    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]       r_dvd;
    logic [DIV_W-1:0]       r_quo;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_dsr;
    logic [DIV_W-1:0]       n_dvd;
    logic [DIV_W-1:0]       n_quo;
    logic [VALUE_WIDTH-1:0] n_rem;

    // RADIX_BITS restoring steps per cycle
    always_comb begin
        logic [VALUE_WIDTH:0] v_rem;
        logic [DIV_W-1:0]     v_dvd;
        logic [DIV_W-1:0]     v_quo;
        logic                 v_bit;
        v_rem = {1'b0, r_rem};
        v_dvd = r_dvd;
        v_quo = r_quo;
        for (int k = 0; k < RADIX_BITS; k++) begin
            v_rem = {v_rem[VALUE_WIDTH-1:0], v_dvd[DIV_W-1]};
            v_dvd = {v_dvd[DIV_W-2:0], 1'b0};
            v_bit = (v_rem >= {1'b0, r_dsr});
            if (v_bit) begin
                v_rem = v_rem - {1'b0, r_dsr};
            end
            v_quo = {v_quo[DIV_W-2:0], v_bit};
        end
        n_rem = v_rem[VALUE_WIDTH-1:0];
        n_dvd = v_dvd;
        n_quo = v_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= DIV_W'(i_dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= n_dvd;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo[VALUE_WIDTH-1:0];
    assign o_rem  = r_rem;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy)
        else $error("divider started while busy");
`endif

endmodule

// File: sv/dpe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_seq: microprogram sequencer
// step counter, control store and conditional jump logic
// ----------------------------------------------------------------------------
module dpe_seq import dpe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_SQR   = 4'd1;
    localparam logic [STEP_W-1:0] ST_TEST  = 4'd2;
    localparam logic [STEP_W-1:0] ST_WAIT  = 4'd3;
    localparam logic [STEP_W-1:0] ST_CHECK = 4'd4;
    localparam logic [STEP_W-1:0] ST_EMIT  = 4'd5;
    localparam logic [STEP_W-1:0] ST_INC   = 4'd6;
    localparam logic [STEP_W-1:0] ST_FIN   = 4'd7;
    localparam logic [STEP_W-1:0] ST_BACK  = 4'd8;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ucw              w_ucw;
    logic              w_take;

    // control store
    always_comb begin
        unique case (r_step)
            ST_IDLE:  w_ucw = '{OP_LOAD,   C_NO_REQ,    1'b1, ST_IDLE};
            ST_SQR:   w_ucw = '{OP_SQUARE, C_NEXT,      1'b0, ST_IDLE};
            ST_TEST:  w_ucw = '{OP_DIV_GO, C_TEST_FAIL, 1'b1, ST_FIN};
            ST_WAIT:  w_ucw = '{OP_NOP,    C_DIV_BUSY,  1'b0, ST_WAIT};
            ST_CHECK: w_ucw = '{OP_NOP,    C_NO_HIT,    1'b0, ST_INC};
            ST_EMIT:  w_ucw = '{OP_EMIT,   C_OUT_BUSY,  1'b1, ST_EMIT};
            ST_INC:   w_ucw = '{OP_INC,    C_ALWAYS,    1'b0, ST_SQR};
            ST_FIN:   w_ucw = '{OP_FINISH, C_OUT_BUSY,  1'b1, ST_FIN};
            ST_BACK:  w_ucw = '{OP_NOP,    C_ALWAYS,    1'b0, ST_IDLE};
            default:  w_ucw = '{OP_NOP,    C_ALWAYS,    1'b0, ST_IDLE};
        endcase
    end

    always_comb begin
        unique case (w_ucw.cond)
            C_NEXT:      w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_REQ:    w_take = !i_flags.req_valid;
            C_TEST_FAIL: w_take = i_flags.test_fail;
            C_DIV_BUSY:  w_take = i_flags.div_busy;
            C_NO_HIT:    w_take = i_flags.no_hit;
            C_OUT_BUSY:  w_take = i_flags.out_busy;
            default:     w_take = 1'b0;
        endcase
    end

    assign n_step     = w_take ? w_ucw.target : r_step + 1'b1;
    assign o_ctl.op   = w_ucw.op;
    assign o_ctl.fire = !(w_ucw.gate && w_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_to_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == OP_LOAD && o_ctl.fire) |=> (r_step == ST_SQR))
        else $error("accepted request did not start the candidate loop");
`endif

endmodule

// File: sv/dpe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpe_dp: datapath of the divisor pair enumerator
// operand registers, squarer, divider, pending pair and output register
// ----------------------------------------------------------------------------
module dpe_dp import dpe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    output t_flags             o_flags,
    input  logic               i_req_valid,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [FIELD_W-1:0] i_value,
    input  logic [FIELD_W-1:0] i_bound,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output logic [FIELD_W-1:0] o_first_factor,
    output logic [FIELD_W-1:0] o_second_factor,
    output logic               o_pair_valid,
    output logic               o_last
);

    t_mode                  r_mode;
    logic [VALUE_WIDTH-1:0] r_n;
    logic [VALUE_WIDTH-1:0] r_lim;
    logic [VALUE_WIDTH-1:0] r_cand;
    logic                   r_dead;
    logic [SQ_W-1:0]        r_sq;
    logic                   r_pend_vld;
    logic [VALUE_WIDTH-1:0] r_pend_a;
    logic [VALUE_WIDTH-1:0] r_pend_b;
    logic                   r_ovld;
    logic [VALUE_WIDTH-1:0] r_o_a;
    logic [VALUE_WIDTH-1:0] r_o_b;
    logic                   r_o_pv;
    logic                   r_o_last;

    logic [VALUE_WIDTH-1:0] w_value;
    logic [VALUE_WIDTH-1:0] w_bound;
    logic [SQ_W-1:0]        w_sq;
    logic                   w_load, w_square, w_go, w_emit, w_inc, w_finish;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_div_busy;
    logic [VALUE_WIDTH-1:0] w_quot;
    logic [VALUE_WIDTH-1:0] w_rem;

    assign w_value  = i_value[VALUE_WIDTH-1:0];
    assign w_bound  = i_bound[VALUE_WIDTH-1:0];
    assign w_sq     = SQ_W'(r_cand) * SQ_W'(r_cand);

    assign w_load   = i_ctl.fire && (i_ctl.op == OP_LOAD);
    assign w_square = i_ctl.fire && (i_ctl.op == OP_SQUARE);
    assign w_go     = i_ctl.fire && (i_ctl.op == OP_DIV_GO);
    assign w_emit   = i_ctl.fire && (i_ctl.op == OP_EMIT);
    assign w_inc    = i_ctl.fire && (i_ctl.op == OP_INC);
    assign w_finish = i_ctl.fire && (i_ctl.op == OP_FINISH);

    assign w_out_free = !r_ovld || i_rsp_ready;
    assign w_out_load = (w_emit && r_pend_vld) || w_finish;

    dpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_go),
        .i_dividend (r_n),
        .i_divisor  (r_cand),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_flags.req_valid = i_req_valid;
    assign o_flags.test_fail = r_dead || (r_sq > SQ_W'(r_n));
    assign o_flags.div_busy  = w_div_busy;
    assign o_flags.no_hit    = (w_rem != '0) || ((r_mode == MODE_MAX) && (r_cand > r_lim));
    assign o_flags.out_busy  = !w_out_free;

    assign o_req_ready = (i_ctl.op == OP_LOAD);

    // operand and candidate registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mode <= t_mode'(i_kind);
            r_n    <= w_value;
            r_lim  <= w_bound;
            r_dead <= (i_kind == MODE_UNUSED) || (w_value == '0);
            if ((i_kind == MODE_MIN) && (w_bound > VALUE_WIDTH'(1))) begin
                r_cand <= w_bound;
            end else begin
                r_cand <= VALUE_WIDTH'(1);
            end
        end else if (w_inc) begin
            r_cand <= r_cand + 1'b1;
        end
        if (w_square) begin
            r_sq <= w_sq;
        end
    end

    // pending pair: held back until it is known whether it is the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (w_emit) begin
            r_pend_vld <= 1'b1;
        end else if (w_finish) begin
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_mode == MODE_ALL) begin
                r_pend_a <= w_quot;
                r_pend_b <= r_cand;
            end else begin
                r_pend_a <= r_cand;
                r_pend_b <= w_quot;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_a    <= r_pend_vld ? r_pend_a : '0;
            r_o_b    <= r_pend_vld ? r_pend_b : '0;
            r_o_pv   <= r_pend_vld;
            r_o_last <= w_finish;
        end
    end

    assign o_rsp_valid     = r_ovld;
    assign o_first_factor  = FIELD_W'(r_o_a);
    assign o_second_factor = FIELD_W'(r_o_b);
    assign o_pair_valid    = r_o_pv;
    assign o_last          = r_o_last;

`ifndef NO_ASSERTIONS
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("output register overwritten while stalled");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !r_pend_vld)
        else $error("pending pair left over at request accept");

    a_finish_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_ovld && r_o_last))
        else $error("closing result missing its last flag");
`endif

endmodule

// File: tb/divisor_pair_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_pair_monitor: request/result checker of the divisor pair enumerator
// watches both channels, works out the divisor pairs of every accepted
// request and compares each accepted result with the oldest pair due
// ----------------------------------------------------------------------------
module divisor_pair_monitor import dpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dpe_req_if   i_req,
    dpe_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_PAIRS = 60;

    typedef struct packed {
        logic [FIELD_W-1:0] first_factor;
        logic [FIELD_W-1:0] second_factor;
        logic               pair_valid;
        logic               last;
    } t_pair_result;

    t_pair_result pairs_due[$];
    t_pair_result got;
    t_pair_result due;

    // trial division up to the root; each pair is held back one step so
    // that the final one of the request can carry last
    function automatic void enumerate_divisor_pairs(t_mode kind, logic [FIELD_W-1:0] value,
                                                    logic [FIELD_W-1:0] bound);
        int unsigned  mask;
        int unsigned  n;
        int unsigned  lim;
        int unsigned  cand;
        int unsigned  start_at;
        int           found;
        t_pair_result held;
        mask     = (32'd1 << VALUE_WIDTH) - 1;
        n        = value & mask;
        lim      = bound & mask;
        start_at = (kind == MODE_MIN && lim > 1) ? lim : 1;
        found    = 0;
        held     = '0;
        if (kind != MODE_UNUSED && n != 0) begin
            for (cand = start_at; cand <= 32'hFFFF && cand * cand <= n && found < MAX_PAIRS;
                 cand++) begin
                if (n % cand == 0 && (kind != MODE_MAX || cand <= lim)) begin
                    if (found > 0)
                        pairs_due = {pairs_due, held};
                    if (kind == MODE_ALL) begin
                        held.first_factor  = FIELD_W'(n / cand);
                        held.second_factor = FIELD_W'(cand);
                    end else begin
                        held.first_factor  = FIELD_W'(cand);
                        held.second_factor = FIELD_W'(n / cand);
                    end
                    held.pair_valid = 1'b1;
                    held.last       = 1'b0;
                    found++;
                end
            end
        end
        if (found == 0) begin
            held = '0;
            held.last = 1'b1;
        end else begin
            held.last = 1'b1;
        end
        pairs_due = {pairs_due, held};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pairs_due.delete();
            o_fail_count = 0;
            o_pending <= 0;
        end else begin
            if (i_req.valid && i_req.ready)
                enumerate_divisor_pairs(t_mode'(i_req.kind), i_req.value, i_req.bound);
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.first_factor, i_rsp.second_factor, i_rsp.pair_valid, i_rsp.last};
                if (pairs_due.size() == 0) begin
                    $error("unexpected result: first_factor %0d second_factor %0d",
                           got.first_factor, got.second_factor);
                    o_fail_count++;
                end else begin
                    due = pairs_due.pop_front();
                    if (got.first_factor !== due.first_factor) begin
                        $error("first_factor: expected %0d, actual %0d",
                               due.first_factor, got.first_factor);
                        o_fail_count++;
                    end
                    if (got.second_factor !== due.second_factor) begin
                        $error("second_factor: expected %0d, actual %0d",
                               due.second_factor, got.second_factor);
                        o_fail_count++;
                    end
                    if (got.pair_valid !== due.pair_valid) begin
                        $error("pair_valid: expected %0b, actual %0b",
                               due.pair_valid, got.pair_valid);
                        o_fail_count++;
                    end
                    if (got.last !== due.last) begin
                        $error("last: expected %0b, actual %0b", due.last, got.last);
                        o_fail_count++;
                    end
                end
            end
            o_pending <= pairs_due.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the divisor pair enumerator
// directed corner requests, then random requests under three idling phases;
// a separate monitor predicts and checks every result
// ----------------------------------------------------------------------------
module tb;
    import dpe_pkg::*;

    // longest correct silence is one full-width trial division plus stalls;
    // the watchdog limit is set well above it
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int RANDOM_REQUESTS = 248;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int send_idle_pct = 32;
    int recv_idle_pct = 76;
    int requests_sent = 0;
    int quiet_cycles  = 0;
    int fail_count;
    int pending;

    // values with many divisors, perfect squares, a large prime, the extremes
    logic [FIELD_W-1:0] rich_values [8] = '{16'd0, 16'd1, 16'd2, 16'd55440,
                                            16'd65535, 16'd65025, 16'd50400, 16'd65521};

    dpe_req_if req_ch ();
    dpe_rsp_if rsp_ch ();

    divisor_pair_enumerator uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    divisor_pair_monitor pair_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: ends the run if no request and no result moves for too long
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request: optional random gap, then hold valid until the handshake
    task automatic send_request(input t_mode kind, input logic [FIELD_W-1:0] value,
                                input logic [FIELD_W-1:0] bound);
        int gap;
        // idling phases: sender light / receiver heavy, swapped, then none
        if (requests_sent < 90) begin
            send_idle_pct = 32;
            recv_idle_pct = 76;
        end else if (requests_sent < 180) begin
            send_idle_pct = 76;
            recv_idle_pct = 32;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        req_ch.bound <= bound;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // stop sending and wait until every predicted pair has come back;
    // the first edge lets the monitor count the request just accepted
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        t_mode              kind;
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] bound;
        int                 pick;

        req_ch.valid <= 1'b0;
        req_ch.kind  <= MODE_ALL;
        req_ch.value <= '0;
        req_ch.bound <= '0;
        rst_n        <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero value, one, extremes, squares, prime, full pair list
        send_request(MODE_ALL, 16'd0, 16'd0);
        send_request(MODE_ALL, 16'd1, 16'd0);
        send_request(MODE_ALL, 16'd4, 16'd0);
        send_request(MODE_ALL, 16'd65535, 16'd65535);
        send_request(MODE_ALL, 16'd65025, 16'd0);
        send_request(MODE_ALL, 16'd65521, 16'd0);
        send_request(MODE_ALL, 16'd55440, 16'd0);
        // upper limit: zero bound gives the empty list, wide bound keeps all
        send_request(MODE_MAX, 16'd720, 16'd0);
        send_request(MODE_MAX, 16'd97, 16'd1);
        send_request(MODE_MAX, 16'd720, 16'd10);
        send_request(MODE_MAX, 16'd55440, 16'd65535);
        send_request(MODE_MAX, 16'd0, 16'd65535);
        // lower limit: zero and one start at one, root exact, above the root
        send_request(MODE_MIN, 16'd36, 16'd0);
        send_request(MODE_MIN, 16'd36, 16'd1);
        send_request(MODE_MIN, 16'd36, 16'd6);
        send_request(MODE_MIN, 16'd36, 16'd7);
        send_request(MODE_MIN, 16'd65025, 16'd255);
        send_request(MODE_MIN, 16'd65535, 16'd65535);
        send_request(MODE_MIN, 16'd0, 16'd3);
        // unused mode always gives the empty list
        send_request(MODE_UNUSED, 16'd55440, 16'd5);
        send_request(MODE_UNUSED, 16'd0, 16'd0);
        send_request(MODE_UNUSED, 16'd65535, 16'd65535);

        // hold off until the block has delivered everything so far
        drain_results();

        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (requests_sent == 90)
                drain_results();

            pick = $urandom_range(0, 9);
            kind = (pick == 9) ? MODE_UNUSED : t_mode'(pick / 3);

            // mostly small values to keep trial division short, some full width
            pick = $urandom_range(99);
            if (pick < 55)
                value = FIELD_W'($urandom_range(1, 1023));
            else if (pick < 65)
                value = FIELD_W'($urandom_range(1, 255) * $urandom_range(1, 255));
            else if (pick < 90)
                value = FIELD_W'($urandom);
            else
                value = rich_values[3'($urandom_range(0, 7))];

            // bound mostly around the root so both limit modes cut the list
            if ($urandom_range(99) < 80)
                bound = FIELD_W'($urandom_range(0, (value < 16'd1024) ? 34 : 260));
            else
                bound = FIELD_W'($urandom);

            send_request(kind, value, bound);
        end

        drain_results();
        repeat (64) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/dpe_pkg.sv
sv/dpe_req_if.sv
sv/dpe_rsp_if.sv
sv/dpe_div.sv
sv/dpe_seq.sv
sv/dpe_dp.sv
sv/divisor_pair_enumerator.sv
tb/divisor_pair_monitor.sv
tb/tb.sv
